/* hw/rtl/dcqcn_pkg.sv */
`timescale 1ns / 1ps

package dcqcn_pkg;

    localparam int FLOWS_DEF = 1024;

    localparam int ACT_W   = 2;
    localparam int FLOW_W  = 10;
    localparam int RATE_W  = 19;
    localparam int ALPHA_W = 17;
    localparam int INC_W   = 14;
    localparam int GAIN_W  = 4;

    // alpha of 1.0 in Q1.16
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    // action codes; anything else is a query
    localparam logic [ACT_W-1:0] ACT_CNP   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TIMER = 2'd1;

    // register indexes
    localparam logic [1:0] REG_LINE_RATE = 2'd0;
    localparam logic [1:0] REG_RATE_INC  = 2'd1;
    localparam logic [1:0] REG_MIN_RATE  = 2'd2;
    localparam logic [1:0] REG_GAIN      = 2'd3;

    localparam logic [RATE_W-1:0] LINE_RATE_RST = 19'd100000;
    localparam logic [INC_W-1:0]  RATE_INC_RST  = 14'd40;
    localparam logic [RATE_W-1:0] MIN_RATE_RST  = 19'd1000;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 4'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_IDX,
        S_READ,
        S_MUL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               valid;
        logic               flag;
        logic [ALPHA_W-1:0] alpha;
        logic [RATE_W-1:0]  rate;
    } entry_t;

endpackage

/* hw/rtl/dcqcn_rate_reaction.sv */
`timescale 1ns / 1ps

// Per-flow DCQCN reaction point. Each input word names an action (CNP, rate
// timer expiry, query) on tuser and a flow on tdata; the block returns one word
// per input with the flow's rate in Mbps, its alpha in Q1.16 and an arm_timer
// flag. Flow state lives in a table of FLOWS entries (1024 by default) holding
// valid, CNP flag, alpha and rate, with a registered read port and a separate
// write port. After reset the block sweeps the table to clear every valid bit,
// one entry per cycle, so s_axis_tready stays low until the sweep is done; APB
// writes are taken throughout. Items are then handled one at a time: after
// acceptance the sequencer steps through its divide, index, read / update,
// multiply and write-back states before the next acceptance. A finished word
// waits in the output register, and a new item may be accepted while it does;
// the write-back stalls only if a second result is ready before the first has
// been taken. Configuration must only be written while no item is in flight.

module dcqcn_rate_reaction
    import dcqcn_pkg::*;
#(
    parameter int FLOWS = FLOWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] flow, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] action

    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [18:0] rate_mbps, [35:19] alpha_q16,
                                        // [36] arm_timer, rest zero
);

    localparam int IDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;

    // flow % FLOWS by reciprocal: the estimate is exact or one short
    localparam logic [19:0] RECIP   = 20'((32'd1 << 20) / FLOWS);
    localparam logic [16:0] FLOWS_C = 17'(FLOWS);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [RATE_W-1:0] line_rate_reg;
    logic [INC_W-1:0]  rate_inc_reg;
    logic [RATE_W-1:0] min_rate_reg;
    logic [GAIN_W-1:0] gain_reg;

    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_rate_reg <= LINE_RATE_RST;
            rate_inc_reg  <= RATE_INC_RST;
            min_rate_reg  <= MIN_RATE_RST;
            gain_reg      <= GAIN_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_LINE_RATE: line_rate_reg <= pwdata[RATE_W-1:0];
                REG_RATE_INC:  rate_inc_reg  <= pwdata[INC_W-1:0];
                REG_MIN_RATE:  min_rate_reg  <= pwdata[RATE_W-1:0];
                REG_GAIN:      gain_reg      <= pwdata[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LINE_RATE: prdata = 32'(line_rate_reg);
            REG_RATE_INC:  prdata = 32'(rate_inc_reg);
            REG_MIN_RATE:  prdata = 32'(min_rate_reg);
            REG_GAIN:      prdata = 32'(gain_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // flow table
    // ---------------------------------------------------------------
    entry_t             flow_mem [FLOWS];
    entry_t             rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flow_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= flow_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [ACT_W-1:0]   action_reg, action_next;
    logic [FLOW_W-1:0]  flow_reg, flow_next;
    logic [FLOW_W-1:0]  quot_reg, quot_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic               flag_reg, flag_next;
    logic [35:0]        prod_reg, prod_next;
    logic               out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]  out_rate_reg, out_rate_next;
    logic [ALPHA_W-1:0] out_alpha_reg, out_alpha_next;
    logic               out_arm_reg, out_arm_next;

    // combinational helpers
    logic [29:0]        div_prod;
    logic [26:0]        back_prod;
    logic [FLOW_W-1:0]  rem;
    logic [FLOW_W-1:0]  rem_fix;
    logic [RATE_W-1:0]  ld_rate;
    logic [ALPHA_W:0]   ld_alpha;
    logic               ld_flag;
    logic [ALPHA_W:0]   alpha_dec;
    logic [ALPHA_W:0]   alpha_up;
    logic [ALPHA_W:0]   factor;
    logic [RATE_W-1:0]  rate_cut;
    logic [RATE_W:0]    rate_sum;
    logic [RATE_W-1:0]  rate_fin;
    logic               flag_fin;
    logic               arm_fin;
    logic [RATE_W-1:0]  arm_thresh;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        action_next    = action_reg;
        flow_next      = flow_reg;
        quot_next      = quot_reg;
        idx_next       = idx_reg;
        rate_next      = rate_reg;
        alpha_next     = alpha_reg;
        flag_next      = flag_reg;
        prod_next      = prod_reg;
        out_rate_next  = out_rate_reg;
        out_alpha_next = out_alpha_reg;
        out_arm_next   = out_arm_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;

        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;

        // index from quotient estimate
        back_prod = {17'b0, quot_reg} * {10'b0, FLOWS_C};
        rem       = flow_reg - back_prod[FLOW_W-1:0];
        rem_fix   = ({7'b0, rem} >= FLOWS_C) ? rem - FLOWS_C[FLOW_W-1:0] : rem;
        rd_addr   = IDX_W'(rem_fix);

        div_prod = {20'b0, flow_reg} * {10'b0, RECIP};

        // untouched entry reads as line rate, alpha 1.0, flag clear
        ld_rate  = rd_data_reg.valid ? rd_data_reg.rate : line_rate_reg;
        ld_alpha = rd_data_reg.valid ? {1'b0, rd_data_reg.alpha} : {1'b0, ALPHA_ONE};
        ld_flag  = rd_data_reg.valid & rd_data_reg.flag;

        alpha_dec = ld_alpha - (ld_alpha >> gain_reg);
        alpha_up  = alpha_dec + ({1'b0, ALPHA_ONE} >> gain_reg);

        factor = 18'd131072 - {1'b0, alpha_reg};

        // final update
        rate_cut   = prod_reg[35:17];
        rate_sum   = {1'b0, rate_reg} + {6'b0, rate_inc_reg};
        arm_thresh = line_rate_reg - (line_rate_reg >> 10);
        rate_fin   = rate_reg;
        flag_fin   = flag_reg;
        arm_fin    = 1'b0;
        if (action_reg == ACT_CNP)
        begin
            rate_fin = (rate_cut < min_rate_reg) ? min_rate_reg : rate_cut;
            flag_fin = 1'b1;
            arm_fin  = 1'b1;
        end
        else if (action_reg == ACT_TIMER)
        begin
            if (flag_reg)
            begin
                flag_fin = 1'b0;
            end
            else
            begin
                rate_fin = (rate_sum > {1'b0, line_rate_reg}) ? line_rate_reg
                                                              : rate_sum[RATE_W-1:0];
            end
            arm_fin = (rate_fin < arm_thresh);
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                if (clr_cnt_reg == IDX_W'(FLOWS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    action_next = s_axis_tuser;
                    flow_next   = s_axis_tdata[FLOW_W-1:0];
                    state_next  = S_DIV;
                end
            end

            S_DIV:
            begin
                quot_next  = div_prod[29:20];
                state_next = S_IDX;
            end

            S_IDX:
            begin
                rd_en      = 1'b1;
                idx_next   = rd_addr;
                state_next = S_READ;
            end

            S_READ:
            begin
                rate_next = ld_rate;
                flag_next = ld_flag;
                if (action_reg == ACT_CNP)
                begin
                    alpha_next = (alpha_up > {1'b0, ALPHA_ONE}) ? ALPHA_ONE
                                                                : alpha_up[ALPHA_W-1:0];
                end
                else if (action_reg == ACT_TIMER)
                begin
                    alpha_next = alpha_dec[ALPHA_W-1:0];
                end
                else
                begin
                    alpha_next = ld_alpha[ALPHA_W-1:0];
                end
                state_next = S_MUL;
            end

            S_MUL:
            begin
                prod_next  = 36'({17'b0, rate_reg} * {18'b0, factor});
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // wait while a previous word is still unclaimed
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_rate_next  = rate_fin;
                    out_alpha_next = alpha_reg;
                    out_arm_next   = arm_fin;
                    if (action_reg == ACT_CNP || action_reg == ACT_TIMER)
                    begin
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b1;
                        wr_data.flag  = flag_fin;
                        wr_data.alpha = alpha_reg;
                        wr_data.rate  = rate_fin;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        flow_reg      <= flow_next;
        quot_reg      <= quot_next;
        idx_reg       <= idx_next;
        rate_reg      <= rate_next;
        alpha_reg     <= alpha_next;
        flag_reg      <= flag_next;
        prod_reg      <= prod_next;
        out_rate_reg  <= out_rate_next;
        out_alpha_reg <= out_alpha_next;
        out_arm_reg   <= out_arm_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b0, out_arm_reg, out_alpha_reg, out_rate_reg};

endmodule
